FILE: hw/rtl/vdps_pkg.sv
`timescale 1ns / 1ps

package vdps_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int CHANNEL_W   = 1;
	localparam int STEP_IN_W   = 19;
	localparam int DELAY_DEPTH = 4096;
	localparam int CHANNELS    = 2;
	localparam int FRAC_BITS   = 16;

	localparam int IDX_W     = $clog2(DELAY_DEPTH);
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W    = CH_W + IDX_W;
	localparam int MEM_DEPTH = (1 << CH_W) * DELAY_DEPTH;
	localparam int POS_W     = IDX_W + FRAC_BITS;
	localparam int FILL_W    = IDX_W + 1;

	localparam int STEP_SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int STEP_SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int STEP_W    = STEP_IN_W + STEP_SH_L;
	localparam int SUM_W     = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;

	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = STEP_IN_W;

	localparam logic [CFG_IDX_W-1:0] REG_BYPASS     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_STEP = CFG_IDX_W'(1);

	localparam logic [STEP_IN_W-1:0] STEP_RESET = STEP_IN_W'(65536);

	typedef struct packed {
		logic                 byp;
		logic [SAMPLE_W-1:0]  sample;
		logic [FRAC_BITS-1:0] frac;
		logic                 fwd_a;
		logic                 fwd_b;
		logic                 zero_a;
		logic                 zero_b;
	} req_t;

	function automatic logic [STEP_W-1:0] scale_step(input logic [STEP_IN_W-1:0] s);
		return (STEP_W'(s) << STEP_SH_L) >> STEP_SH_R;
	endfunction

endpackage

FILE: hw/rtl/vdps_store.sv
`timescale 1ns / 1ps

module vdps_store
	import vdps_pkg::*;
(
	input  logic                clk,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr_a,
	input  logic [ADDR_W-1:0]   rd_addr_b,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  logic [SAMPLE_W-1:0] wr_data,
	output logic [SAMPLE_W-1:0] rd_data_a,
	output logic [SAMPLE_W-1:0] rd_data_b
);

	logic [SAMPLE_W-1:0] mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

FILE: hw/rtl/vdps_ctrl.sv
`timescale 1ns / 1ps

module vdps_ctrl
	import vdps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [CHANNEL_W-1:0]  channel,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output req_t                  req,
	output logic                  wr_en,
	output logic [ADDR_W-1:0]     wr_addr,
	output logic [ADDR_W-1:0]     rd_addr_a,
	output logic [ADDR_W-1:0]     rd_addr_b
);

	logic                 bypass_q;
	logic [STEP_IN_W-1:0] step_q;
	logic [POS_W-1:0]     pos_q  [CHANNELS];
	logic [IDX_W-1:0]     wi_q   [CHANNELS];
	logic [FILL_W-1:0]    fill_q [CHANNELS];

	logic [CH_W-1:0]   ch_idx;
	logic              ch_ok;
	logic              byp;
	logic [POS_W-1:0]  pos;
	logic [IDX_W-1:0]  wi;
	logic [FILL_W-1:0] fill;
	logic [IDX_W-1:0]  idx_a;
	logic [IDX_W-1:0]  idx_b;
	logic [POS_W-1:0]  pos_next;

	assign cfg_ready = 1'b1;

	assign ch_idx = CH_W'(channel);
	assign ch_ok  = (32'(channel) < CHANNELS);
	assign byp    = bypass_q || !ch_ok;

	assign pos  = pos_q[ch_idx];
	assign wi   = wi_q[ch_idx];
	assign fill = fill_q[ch_idx];

	assign idx_a = pos[POS_W-1:FRAC_BITS];
	assign idx_b = idx_a + IDX_W'(1);

	assign pos_next = POS_W'(SUM_W'(pos) + SUM_W'(scale_step(step_q)));

	assign wr_en     = accept && !byp;
	assign wr_addr   = {ch_idx, wi};
	assign rd_addr_a = {ch_idx, idx_a};
	assign rd_addr_b = {ch_idx, idx_b};

	// entries at or beyond the fill count were never written and read as zero
	always_comb begin
		req.byp    = byp;
		req.sample = sample;
		req.frac   = pos[FRAC_BITS-1:0];
		req.fwd_a  = (idx_a == wi);
		req.fwd_b  = (idx_b == wi);
		req.zero_a = (FILL_W'(idx_a) >= fill) && (idx_a != wi);
		req.zero_b = (FILL_W'(idx_b) >= fill) && (idx_b != wi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			step_q   <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BYPASS:     bypass_q <= cfg_data[0];
				REG_PITCH_STEP: step_q   <= cfg_data[STEP_IN_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c]  <= '0;
				wi_q[c]   <= '0;
				fill_q[c] <= '0;
			end
		end else if (wr_en) begin
			pos_q[ch_idx] <= pos_next;
			wi_q[ch_idx]  <= wi + IDX_W'(1);
			if (fill != FILL_W'(DELAY_DEPTH)) begin
				fill_q[ch_idx] <= fill + FILL_W'(1);
			end
		end
	end

	a_fill_tracks_wi: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (fill == FILL_W'(DELAY_DEPTH) || FILL_W'(wi) == fill))
		else $error("fill count and write index disagree");

endmodule

FILE: hw/rtl/vdps_interp.sv
`timescale 1ns / 1ps

module vdps_interp
	import vdps_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  req_t                       req,
	output logic                       take,
	input  logic [SAMPLE_W-1:0]        rd_data_a,
	input  logic [SAMPLE_W-1:0]        rd_data_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out
);

	logic en_s2;
	logic en_s3;
	logic en_o;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic vo_q;

	req_t req_s1;

	logic [SAMPLE_W-1:0] a_sel;
	logic [SAMPLE_W-1:0] b_sel;

	logic                     byp_s2;
	logic [SAMPLE_W-1:0]      x_s2;
	logic [SAMPLE_W-1:0]      a_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	logic [FRAC_BITS-1:0]     frac_s2;

	logic signed [PROD_W-1:0] prod;

	logic                     byp_s3;
	logic [SAMPLE_W-1:0]      x_s3;
	logic [SAMPLE_W-1:0]      a_s3;
	logic signed [PROD_W-1:0] prod_s3;

	logic [SAMPLE_W-1:0] y;
	logic [SAMPLE_W-1:0] sample_out_q;

	assign en_o  = !vo_q || !out_stall;
	assign en_s3 = !v_s3 || en_o;
	assign en_s2 = !v_s2 || en_s3;
	assign take  = !v_s1 || en_s2;

	assign a_sel = req_s1.fwd_a ? req_s1.sample : (req_s1.zero_a ? '0 : rd_data_a);
	assign b_sel = req_s1.fwd_b ? req_s1.sample : (req_s1.zero_b ? '0 : rd_data_b);

	assign prod = PROD_W'($signed({1'b0, frac_s2})) * PROD_W'(diff_s2);

	// arithmetic shift by taking upper bits floors the scaled product
	assign y = a_s3 + prod_s3[FRAC_BITS +: SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (take)  v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_o)  vo_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
		if (en_s2) begin
			byp_s2  <= req_s1.byp;
			x_s2    <= req_s1.sample;
			a_s2    <= a_sel;
			diff_s2 <= $signed({b_sel[SAMPLE_W-1], b_sel}) - $signed({a_sel[SAMPLE_W-1], a_sel});
			frac_s2 <= req_s1.frac;
		end
		if (en_s3) begin
			byp_s3  <= byp_s2;
			x_s3    <= x_s2;
			a_s3    <= a_s2;
			prod_s3 <= prod;
		end
		if (en_o) begin
			sample_out_q <= byp_s3 ? x_s3 : y;
		end
	end

	assign out_valid  = vo_q;
	assign sample_out = $signed(sample_out_q);

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!take |-> (v_s1 && v_s2 && v_s3 && vo_q))
		else $error("input held back while the pipeline has a bubble");

	a_s3_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en_o) |=> vo_q)
		else $error("result lost between last stage and output register");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vo_q && out_stall) |=> (vo_q && $stable(sample_out_q)))
		else $error("stalled result dropped or changed");

endmodule

FILE: hw/rtl/varispeed_delay_pitch_shifter.sv
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// in        in_valid / in_stall      channel, sample_in
// out       out_valid / out_stall    sample_out
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One sample per cycle sustained while out_stall is low; out_valid rises once the result has passed
// one register each for the store read, the subtract, the multiply and the final add.
// Both store reads and the write of one sample share a single cycle of the delay store.
// No clearing pass after reset: a per-channel fill count masks entries never written.
// An output stall backs up the four-stage pipeline; input stalls only when every stage is full.

module varispeed_delay_pitch_shifter
	import vdps_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [CHANNEL_W-1:0]       channel,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	logic                take;
	logic                accept;
	req_t                req;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   rd_addr_a;
	logic [ADDR_W-1:0]   rd_addr_b;
	logic [SAMPLE_W-1:0] rd_data_a;
	logic [SAMPLE_W-1:0] rd_data_b;

	assign in_stall = !take;
	assign accept   = in_valid && take;

	vdps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.channel   (channel),
		.sample    (sample_in),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b)
	);

	vdps_store u_store (
		.clk       (clk),
		.rd_en     (take),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (sample_in),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	vdps_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.req        (req),
		.take       (take),
		.rd_data_a  (rd_data_a),
		.rd_data_b  (rd_data_b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

endmodule

FILE: bench/pitch_checker.sv
`timescale 1ns / 1ps

module pitch_checker
	import vdps_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [CHANNEL_W-1:0]       channel,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [SAMPLE_W-1:0] sample_out,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output int                         fails,
	output int                         results_seen
);

	logic signed [SAMPLE_W-1:0] echo_mem [CHANNELS][DELAY_DEPTH];
	int                         wr_ptr [CHANNELS];
	longint                     rd_pos [CHANNELS];
	logic                       byp_cfg;
	logic [STEP_IN_W-1:0]       step_cfg;
	logic signed [SAMPLE_W-1:0] shifted_q [$];

	function automatic logic signed [SAMPLE_W-1:0] shift_sample(
		input logic [CHANNEL_W-1:0] ch,
		input logic signed [SAMPLE_W-1:0] x
	);
		int     c;
		int     i1;
		int     i2;
		longint span;
		longint stride;
		longint pos;
		longint fr;
		longint s1;
		longint s2;
		longint y;
		c = int'(ch);
		if (byp_cfg || c >= CHANNELS)
			return x;
		echo_mem[c][wr_ptr[c]] = x;
		span = longint'(DELAY_DEPTH) << FRAC_BITS;
		if (FRAC_BITS >= 16)
			stride = longint'(step_cfg) << (FRAC_BITS - 16);
		else
			stride = longint'(step_cfg) >> (16 - FRAC_BITS);
		pos = rd_pos[c] % span;
		fr = pos & ((longint'(1) << FRAC_BITS) - 1);
		i1 = int'((pos >> FRAC_BITS) % DELAY_DEPTH);
		i2 = (i1 + 1) % DELAY_DEPTH;
		s1 = echo_mem[c][i1];
		s2 = echo_mem[c][i2];
		// arithmetic shift of a signed product floors toward minus infinity
		y = s1 + ((fr * (s2 - s1)) >>> FRAC_BITS);
		rd_pos[c] = (pos + stride) % span;
		wr_ptr[c] = (wr_ptr[c] + 1) % DELAY_DEPTH;
		return y[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int k = 0; k < DELAY_DEPTH; k++)
					echo_mem[c][k] = '0;
				wr_ptr[c] = 0;
				rd_pos[c] = 0;
			end
			byp_cfg = 1'b0;
			step_cfg = STEP_RESET;
			shifted_q.delete();
			fails = 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BYPASS:     byp_cfg = cfg_data[0];
					REG_PITCH_STEP: step_cfg = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (shifted_q.size() == 0) begin
					fails = fails + 1;
					if (fails <= 10)
						$display("unexpected sample_out transfer: %0d", sample_out);
				end else begin
					want = shifted_q.pop_front();
					if (sample_out !== want) begin
						fails = fails + 1;
						if (fails <= 10)
							$display("sample_out mismatch: expected %0d (%h), got %0d (%h)",
								want, want, sample_out, sample_out);
					end
				end
			end
			if (in_valid && !in_stall)
				shifted_q.push_back(shift_sample(channel, sample_in));
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import vdps_pkg::*;

	localparam logic [STEP_IN_W-1:0] STEP_SLOWEST = STEP_IN_W'(16384);
	localparam logic [STEP_IN_W-1:0] STEP_FASTEST = STEP_IN_W'(262144);
	localparam logic [STEP_IN_W-1:0] STEP_FULL    = '1;
	localparam logic [STEP_IN_W-1:0] STEP_HALT    = '0;
	localparam logic signed [SAMPLE_W-1:0] S_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [CHANNEL_W-1:0]       channel = '0;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	int fails;
	int results_seen;
	int sent = 0;
	bit calm = 1'b0;

	varispeed_delay_pitch_shifter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.channel    (channel),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	pitch_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.channel      (channel),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fails        (fails),
		.results_seen (results_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	task automatic send(input logic [CHANNEL_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s);
		if (!calm) begin
			while ($urandom_range(99) < 34) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		channel <= ch;
		sample_in <= s;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic drain();
		while (results_seen != sent) @(posedge clk);
	endtask

	// step first, then optionally a write to an unused index, bypass last
	task automatic program_regs(input logic byp, input logic [STEP_IN_W-1:0] step, input bit stray);
		logic [CFG_DATA_W-1:0] word;
		in_valid <= 1'b0;
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= REG_PITCH_STEP;
		cfg_data <= step;
		do @(posedge clk); while (!cfg_ready);
		if (stray) begin
			cfg_index <= CFG_IDX_W'($urandom_range(15, 2));
			cfg_data <= CFG_DATA_W'($urandom);
			do @(posedge clk); while (!cfg_ready);
		end
		word = CFG_DATA_W'($urandom);
		word[0] = byp;
		cfg_index <= REG_BYPASS;
		cfg_data <= word;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] draw_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2: return SAMPLE_W'($urandom_range(511) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [STEP_IN_W-1:0] draw_step();
		case ($urandom_range(7))
			0: return STEP_SLOWEST;
			1: return STEP_FASTEST;
			2: return STEP_HALT;
			3: return STEP_FULL;
			4: return STEP_RESET;
			5: return STEP_IN_W'($urandom);
			default: return STEP_IN_W'($urandom_range(262144, 16384));
		endcase
	endfunction

	initial begin
		int budget;
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unity step from reset: each read lands on the word just written
		send(0, S_MAX);
		send(0, S_MIN);
		send(1, S_MIN);
		send(0, '0);
		send(1, -1);
		send(1, S_MAX);

		// quarter speed, blend between the extremes of both signs
		program_regs(1'b0, STEP_SLOWEST, 1'b0);
		send(0, S_MIN);
		send(0, S_MAX);
		send(0, -1);
		send(1, 1);
		send(1, S_MIN);
		send(1, S_MAX);

		// every step bit set, then a stopped read position
		program_regs(1'b0, STEP_FULL, 1'b1);
		send(0, S_MAX);
		send(1, S_MIN);
		program_regs(1'b0, STEP_HALT, 1'b0);
		send(0, 24'h555555);
		send(0, 24'hAAAAAA);

		// bypass, with the step changed underneath it
		program_regs(1'b1, STEP_FASTEST, 1'b1);
		send(0, S_MIN);
		send(1, S_MAX);
		send(0, 24'h123456);
		program_regs(1'b0, STEP_FASTEST, 1'b0);
		send(0, S_MAX);
		send(1, S_MIN);
		send(0, 24'hFEDCBA);

		// long fast run, mostly on channel 0, so the read position wraps
		program_regs(1'b0, STEP_FULL, 1'b0);
		for (int k = 0; k < 600; k++) begin
			calm = (k < 250);
			send(CHANNEL_W'($urandom_range(19) == 0), draw_sample());
		end
		calm = 1'b0;

		budget = 500;
		while (budget > 0) begin
			n = $urandom_range(120, 40);
			program_regs($urandom_range(5) == 0, draw_step(), $urandom_range(2) == 0);
			repeat (n) send(CHANNEL_W'($urandom), draw_sample());
			budget -= n;
		end

		in_valid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/vdps_pkg.sv
hw/rtl/vdps_store.sv
hw/rtl/vdps_ctrl.sv
hw/rtl/vdps_interp.sv
hw/rtl/varispeed_delay_pitch_shifter.sv
bench/pitch_checker.sv
bench/testbench.sv
